FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is low.
`define SCFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent check that an expression never holds.
`define SCFD_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `SCFD_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

FILE: rtl/scfd_pkg.sv
package scfd_pkg;

    // Field and port widths.
    localparam int BYTE_W     = 8;
    localparam int TICK_IN_W  = 32;
    localparam int CODE_W     = 6;
    localparam int VOL_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAME_LEN  = 7;
    localparam int CMD_WORDS  = 43;

    // A frame holds its first character in the top byte.
    typedef logic [FRAME_LEN*BYTE_W-1:0] t_frame;

    // One entry of the queue between the framer and the decoder.
    typedef struct packed {
        logic   lead_err;
        t_frame frame;
    } t_job;

    // Configuration registers.
    typedef struct packed {
        logic [31:0]      timeout_ticks;
        logic [VOL_W-1:0] vol_floor;
        logic [VOL_W-1:0] vol_ceiling;
        logic             volume_up_enable;
        logic             volume_down_enable;
        logic             receive_enable;
    } t_cfg;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT   = 3'd0,
        CFG_MIN_VOL   = 3'd1,
        CFG_MAX_VOL   = 3'd2,
        CFG_VOL_UP_EN = 3'd3,
        CFG_VOL_DN_EN = 3'd4,
        CFG_RX_EN     = 3'd5
    } t_cfg_idx;

    localparam t_cfg CFG_RESET = '{
        timeout_ticks:      32'd1000,
        vol_floor:          10'd0,
        vol_ceiling:        10'd100,
        volume_up_enable:   1'b1,
        volume_down_enable: 1'b1,
        receive_enable:     1'b1
    };

    // Event codes; fixed commands take 1 through 43 in table order.
    localparam logic [CODE_W-1:0] EV_UNKNOWN  = 6'd0;
    localparam logic [CODE_W-1:0] EV_VOL_UP   = 6'd44;
    localparam logic [CODE_W-1:0] EV_VOL_DOWN = 6'd45;

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_STAR     = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'd32;
    localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'd126;

    // Volume command.
    localparam logic [4*BYTE_W-1:0] VOL_PREFIX   = "*VOL";
    localparam logic [VOL_W-1:0]    VOL_DOWN_LO  = 10'd900;
    localparam logic [VOL_W-1:0]    VOL_DOWN_HI  = 10'd999;
    localparam logic [VOL_W-1:0]    VOL_DOWN_OFS = 10'd899;

    // Fixed command words.
    localparam t_frame CMD_TABLE [CMD_WORDS] = '{
        "*_ARM__", "*A_CLR1", "*A_CLR2", "*I_WAIL", "*CHEM_A", "*DISARM",
        "*CANCEL", "*Q_TEST", "*_WAIL_", "*P_WAIL", "*YELP__", "*REPORT",
        "*_VOICE", "*RESET_", "*ENTER_", "*UP____", "*DOWN__", "*ESC___",
        "*CNLBTN", "*TEST__", "*ANNOUN", "*MESSAG", "*ALMBTN", "*ARMBTN",
        "*AMP_T1", "*AMP_T2", "*AMP_T3", "*AMP_T4", "*AMP_T5", "*AMP_T6",
        "*AMP_T7", "*AMP_T8", "*AMP_T9", "*AMPT10", "*AMP_ON", "*DRV_ON",
        "*OSC_ON", "*AMP_ST", "*BTN__1", "*BTN__8", "*BTN__9", "*BTNLFT",
        "*BTNRGT"
    };

endpackage

FILE: rtl/scfd_front.sv
module scfd_front #(
    parameter int TICK_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [scfd_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic [scfd_pkg::TICK_IN_W-1:0]  i_tick,
    input  scfd_pkg::t_cfg                  i_cfg,
    output logic                            o_push,
    output scfd_pkg::t_job                  o_job
);

    localparam int CMP_W = (TICK_WIDTH > scfd_pkg::TICK_IN_W) ? TICK_WIDTH
                                                               : scfd_pkg::TICK_IN_W;
    localparam int STORE_N = scfd_pkg::FRAME_LEN - 1;

    logic [TICK_WIDTH-1:0]          r_last;
    logic [TICK_WIDTH-1:0]          n_last;
    logic [2:0]                     r_cnt;
    logic [2:0]                     n_cnt;
    logic                           r_lead;
    logic                           n_lead;
    logic [scfd_pkg::BYTE_W-1:0]    r_chars [STORE_N];

    logic [CMP_W-1:0]               w_tick_ext;
    logic [TICK_WIDTH-1:0]          w_now;
    logic [TICK_WIDTH-1:0]          w_gap;
    logic                           w_timed_out;
    logic [2:0]                     w_cnt_eff;
    logic                           w_lead_eff;
    logic                           w_printable;
    logic                           w_store;

    // Gap since the previous word, modulo the tick width.
    always_comb begin
        w_tick_ext  = CMP_W'(i_tick);
        w_now       = w_tick_ext[TICK_WIDTH-1:0];
        w_gap       = w_now - r_last;
        w_timed_out = CMP_W'(w_gap) > CMP_W'(i_cfg.timeout_ticks);
        w_cnt_eff   = w_timed_out ? 3'd0 : r_cnt;
        w_lead_eff  = w_timed_out ? 1'b0 : r_lead;
        w_printable = (i_rx_byte >= scfd_pkg::CH_PRINT_LO) &&
                      (i_rx_byte <= scfd_pkg::CH_PRINT_HI);
    end

    // Framing: lead check, character store and frame hand-off.
    always_comb begin
        n_last  = r_last;
        n_cnt   = r_cnt;
        n_lead  = r_lead;
        o_push  = 1'b0;
        w_store = 1'b0;
        o_job.lead_err = 1'b0;
        o_job.frame    = {r_chars[0], r_chars[1], r_chars[2], r_chars[3],
                          r_chars[4], r_chars[5], i_rx_byte};
        if (i_accept) begin
            n_last = w_now;
            n_lead = w_lead_eff;
            if (!i_cfg.receive_enable || !w_printable) begin
                n_cnt = 3'd0;
            end else if (w_cnt_eff == 3'd0 && i_rx_byte != scfd_pkg::CH_STAR) begin
                n_cnt = 3'd0;
                n_lead = 1'b1;
                if (!w_lead_eff) begin
                    o_push = 1'b1;
                    o_job.lead_err = 1'b1;
                end
            end else if (w_cnt_eff == 3'(STORE_N)) begin
                n_cnt  = 3'd0;
                o_push = 1'b1;
            end else begin
                n_cnt   = w_cnt_eff + 3'd1;
                w_store = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_cnt  <= 3'd0;
            r_lead <= 1'b0;
        end else begin
            r_last <= n_last;
            r_cnt  <= n_cnt;
            r_lead <= n_lead;
        end
    end

    // Frame characters are only read once all of them were written.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_chars[w_cnt_eff] <= i_rx_byte;
        end
    end

endmodule

FILE: rtl/scfd_queue.sv
`include "assert_macros.svh"

module scfd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scfd_pkg::t_job  i_data,
    input  logic            i_pop,
    output scfd_pkg::t_job  o_head,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    scfd_pkg::t_job     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `SCFD_ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full && !i_pop, "push into full queue")
    `SCFD_ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")

endmodule

FILE: rtl/scfd_back.sv
`include "assert_macros.svh"

module scfd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  scfd_pkg::t_cfg                  i_cfg,
    input  logic                            i_empty,
    input  scfd_pkg::t_job                  i_head,
    output logic                            o_pop,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [scfd_pkg::CODE_W-1:0]     o_code,
    output logic [scfd_pkg::VOL_W-1:0]      o_arg
);

    localparam logic [scfd_pkg::VOL_W-1:0] DEC_HUNDRED = 10'd100;
    localparam logic [scfd_pkg::VOL_W-1:0] DEC_TEN     = 10'd10;

    logic                               r_valid;
    logic [scfd_pkg::CODE_W-1:0]        r_code;
    logic [scfd_pkg::VOL_W-1:0]         r_arg;
    logic [scfd_pkg::CODE_W-1:0]        w_code;
    logic [scfd_pkg::VOL_W-1:0]         w_arg;

    // Fixed-word match and volume parse of the queue head.
    always_comb begin
        logic [scfd_pkg::CODE_W-1:0]    cmd_code;
        logic [scfd_pkg::BYTE_W-1:0]    ca;
        logic [scfd_pkg::BYTE_W-1:0]    cb;
        logic [scfd_pkg::BYTE_W-1:0]    cc;
        logic                           a_sp;
        logic                           digits_ok;
        logic [3:0]                     da;
        logic [3:0]                     db;
        logic [3:0]                     dc;
        logic [scfd_pkg::VOL_W-1:0]     vol;

        cmd_code = scfd_pkg::EV_UNKNOWN;
        for (int i = 0; i < scfd_pkg::CMD_WORDS; i++) begin
            if (i_head.frame == scfd_pkg::CMD_TABLE[i]) begin
                cmd_code = scfd_pkg::CODE_W'(i + 1);
            end
        end

        ca = i_head.frame[23:16];
        cb = i_head.frame[15:8];
        cc = i_head.frame[7:0];
        a_sp = (ca == scfd_pkg::CH_SPACE);
        digits_ok = (a_sp || (ca >= scfd_pkg::CH_ZERO && ca <= scfd_pkg::CH_NINE)) &&
                    (cb >= scfd_pkg::CH_ZERO && cb <= scfd_pkg::CH_NINE) &&
                    (cc >= scfd_pkg::CH_ZERO && cc <= scfd_pkg::CH_NINE);
        da = a_sp ? 4'd0 : 4'(ca - scfd_pkg::CH_ZERO);
        db = 4'(cb - scfd_pkg::CH_ZERO);
        dc = 4'(cc - scfd_pkg::CH_ZERO);
        vol = scfd_pkg::VOL_W'(da) * DEC_HUNDRED + scfd_pkg::VOL_W'(db) * DEC_TEN
              + scfd_pkg::VOL_W'(dc);

        w_code = scfd_pkg::EV_UNKNOWN;
        w_arg  = '0;
        if (i_head.lead_err) begin
            w_code = scfd_pkg::EV_UNKNOWN;
        end else if (cmd_code != scfd_pkg::EV_UNKNOWN) begin
            w_code = cmd_code;
        end else if (i_head.frame[55:24] == scfd_pkg::VOL_PREFIX && digits_ok) begin
            if (vol >= i_cfg.vol_floor && vol <= i_cfg.vol_ceiling &&
                i_cfg.volume_up_enable) begin
                w_code = scfd_pkg::EV_VOL_UP;
                w_arg  = vol;
            end else if (vol >= scfd_pkg::VOL_DOWN_LO && vol <= scfd_pkg::VOL_DOWN_HI &&
                         i_cfg.volume_down_enable) begin
                w_code = scfd_pkg::EV_VOL_DOWN;
                w_arg  = vol - scfd_pkg::VOL_DOWN_OFS;
            end
        end
    end

    // Take a new entry whenever the output register is free or being drained.
    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code <= w_code;
            r_arg  <= w_arg;
        end
    end

    assign o_valid = r_valid;
    assign o_code  = r_code;
    assign o_arg   = r_arg;

    `SCFD_ASSERT(a_up_in_range, i_clk, i_rst_n, (o_pop && w_code == scfd_pkg::EV_VOL_UP) |=> (r_arg >= i_cfg.vol_floor && r_arg <= i_cfg.vol_ceiling), "volume up outside range")
    `SCFD_ASSERT(a_arg_zero, i_clk, i_rst_n, (o_pop && w_code != scfd_pkg::EV_VOL_UP && w_code != scfd_pkg::EV_VOL_DOWN) |=> (r_arg == '0), "argument set for non-volume event")

endmodule

FILE: rtl/serial_command_frame_decoder_unit.sv
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: rx_byte[7:0], tick_time[39:8]
// m_axis    out  m_axis_tvalid/tready        tdata: event_code[5:0], volume_arg[15:6]
// cfg       in   i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
// One input word per cycle while s_axis_tready is high; a byte that completes a
// frame or trips the lead check is written to the queue, then decoded into the
// output register that drives m_axis_tvalid; one decoder pass per cycle while that register is free or drained.
// The framer feeds a QUEUE_DEPTH entry queue; s_axis_tready drops only while
// that queue is full, which happens when m_axis stalls long enough to fill it.
// Reset is synchronous, active low; it loads configuration defaults and
// empties the queue and output register with no clearing pass.
module serial_command_frame_decoder_unit #(
    parameter int TICK_WIDTH  = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // rx_byte[7:0], tick_time[39:8]
    input  logic [39:0]                         s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // event_code[5:0], volume_arg[15:6]
    output logic [15:0]                         m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [scfd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [scfd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    scfd_pkg::t_cfg                     r_cfg;
    logic                               w_accept;
    logic                               w_push;
    scfd_pkg::t_job                     w_job;
    scfd_pkg::t_job                     w_head;
    logic                               w_full;
    logic                               w_empty;
    logic                               w_pop;
    logic [scfd_pkg::CODE_W-1:0]        w_code;
    logic [scfd_pkg::VOL_W-1:0]         w_arg;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= scfd_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (scfd_pkg::t_cfg_idx'(i_cfg_idx))
                scfd_pkg::CFG_TIMEOUT:   r_cfg.timeout_ticks      <= i_cfg_data;
                scfd_pkg::CFG_MIN_VOL:   r_cfg.vol_floor          <= i_cfg_data[9:0];
                scfd_pkg::CFG_MAX_VOL:   r_cfg.vol_ceiling        <= i_cfg_data[9:0];
                scfd_pkg::CFG_VOL_UP_EN: r_cfg.volume_up_enable   <= i_cfg_data[0];
                scfd_pkg::CFG_VOL_DN_EN: r_cfg.volume_down_enable <= i_cfg_data[0];
                scfd_pkg::CFG_RX_EN:     r_cfg.receive_enable     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && !w_full;

    // Front: timing and framing.
    scfd_front #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (s_axis_tdata[7:0]),
        .i_tick    (s_axis_tdata[39:8]),
        .i_cfg     (r_cfg),
        .o_push    (w_push),
        .o_job     (w_job)
    );

    // Queue between framing and decoding.
    scfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Back: command decode and output register.
    scfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_code  (w_code),
        .o_arg   (w_arg)
    );

    assign m_axis_tdata = {w_arg, w_code};

endmodule
